### hdl/assert_macros.svh
// Assertion macros for the RTL. They compile to nothing when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge outside reset.
`define FBC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: invariant");

// The antecedent in one cycle implies the consequent in the next.
`define FBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define FBC_ASSERT_ALWAYS(lbl, expr)
`define FBC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hdl/fbc_pkg.sv
package fbc_pkg;

  // configuration word and matrix lane geometry
  localparam int CFG_W      = 64;
  localparam int LANE_W     = 16;
  localparam int NUM_COLS   = 4;
  localparam int NUM_PLANES = 6;

  // result queue depth, at least the pipeline latency for full rate
  localparam int FIFO_DEPTH = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_COL0 = 2'd0,
    REG_COL1 = 2'd1,
    REG_COL2 = 2'd2,
    REG_COL3 = 2'd3
  } cfg_idx_t;

  // control passed from cell to cell alongside the box
  typedef struct packed {
    logic valid;
    logic vis;
  } fbc_ctl_t;

endpackage

### hdl/frustum_box_cull.sv
// Path: input transaction to out_tvalid through 6 plane cells x 2 stages,
// the first loaded at the accepting edge, then the queue write.
// Throughput: one box per cycle; input stalls only when 16 results are in flight or queued.
// Each plane cell holds its products in one stage and its distance test in the next.
// Reset (rst_n low at a clock edge, synchronous) clears the matrix registers,
// the chain's valid flags and the result queue.
module frustum_box_cull #(
  parameter int COORD_WIDTH  = 16,
  parameter int MATRIX_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wen,
  input  logic [1:0]                 cfg_index,
  input  logic [fbc_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z from bit 0 up, zero padded
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // visible in bit 0, zero padded
  output logic [7:0]                 out_tdata
);

  localparam int CW  = COORD_WIDTH;
  localparam int BW  = 6 * CW;
  localparam int NP  = fbc_pkg::NUM_PLANES;
  localparam int QD  = fbc_pkg::FIFO_DEPTH;
  localparam int CNW = $clog2(QD + 1);

  logic [fbc_pkg::CFG_W-1:0]                   col_r [fbc_pkg::NUM_COLS];
  logic [fbc_pkg::NUM_COLS*fbc_pkg::CFG_W-1:0] cols;
  logic [BW-1:0]                               box [NP+1];
  fbc_pkg::fbc_ctl_t                           ctl [NP+1];
  logic                                        in_acc, out_acc;
  logic [CNW-1:0]                              cnt_r, cnt_nxt;
  logic                                        q_dout, q_empty;

  // matrix column registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < fbc_pkg::NUM_COLS; j++) begin
        col_r[j] <= '0;
      end
    end else if (cfg_wen) begin
      unique case (fbc_pkg::cfg_idx_t'(cfg_index))
        fbc_pkg::REG_COL0: col_r[0] <= cfg_wdata;
        fbc_pkg::REG_COL1: col_r[1] <= cfg_wdata;
        fbc_pkg::REG_COL2: col_r[2] <= cfg_wdata;
        fbc_pkg::REG_COL3: col_r[3] <= cfg_wdata;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < fbc_pkg::NUM_COLS; j++) begin
      cols[j*fbc_pkg::CFG_W +: fbc_pkg::CFG_W] = col_r[j];
    end
  end

  // credit count: boxes in the chain plus results in the queue
  assign in_acc    = in_tvalid & in_tready;
  assign out_acc   = out_tvalid & out_tready;
  assign in_tready = (cnt_r < CNW'(QD));
  assign cnt_nxt   = cnt_r + CNW'(in_acc) - CNW'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // head of the chain
  assign box[0]       = in_tdata[BW-1:0];
  assign ctl[0].valid = in_acc;
  assign ctl[0].vis   = 1'b1;

  // one cell per clip plane
  for (genvar p = 0; p < NP; p++) begin : g_cell
    fbc_cell #(
      .CW    (COORD_WIDTH),
      .MW    (MATRIX_WIDTH),
      .PLANE (p)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cols    (cols),
      .box_in  (box[p]),
      .ctl_in  (ctl[p]),
      .box_out (box[p+1]),
      .ctl_out (ctl[p+1])
    );
  end

  // result queue
  fbc_fifo #(
    .DEPTH (QD)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ctl[NP].valid),
    .din   (ctl[NP].vis),
    .pop   (out_acc),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign out_tvalid = ~q_empty;
  assign out_tdata  = {7'd0, q_dout};

`include "assert_macros.svh"

  `FBC_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNW'(QD))
  `FBC_ASSERT_ALWAYS(a_out_has_credit, !out_tvalid || (cnt_r != '0))
  `FBC_ASSERT_ALWAYS(a_chain_has_credit, !ctl[NP].valid || (cnt_r != '0))
  `FBC_ASSERT_NEXT(a_cnt_up, in_acc && !out_acc, cnt_r == $past(cnt_r) + CNW'(1))

endmodule

### hdl/fbc_cell.sv
// One clip plane of the chain: two register stages, box and flag handed on.
module fbc_cell #(
  parameter int CW    = 16,
  parameter int MW    = 16,
  parameter int PLANE = 0
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic [fbc_pkg::NUM_COLS*fbc_pkg::CFG_W-1:0]    cols,
  input  logic [6*CW-1:0]                                box_in,
  input  fbc_pkg::fbc_ctl_t                              ctl_in,
  output logic [6*CW-1:0]                                box_out,
  output fbc_pkg::fbc_ctl_t                              ctl_out
);

  localparam int ROW_K = PLANE / 2;
  localparam int SUB   = PLANE % 2;
  localparam int KW    = MW + 1;
  localparam int PW    = KW + CW;
  localparam int SW    = PW + 2;
  localparam int CF    = CW / 2;

  // plane coefficient from one matrix column: row 3 plus or minus row k
  function automatic logic signed [KW-1:0] coef(input logic [fbc_pkg::CFG_W-1:0] col);
    logic signed [KW-1:0] r3;
    logic signed [KW-1:0] rk;
    r3 = KW'($signed(col[3*fbc_pkg::LANE_W +: MW]));
    rk = KW'($signed(col[ROW_K*fbc_pkg::LANE_W +: MW]));
    return (SUB != 0) ? (r3 - rk) : (r3 + rk);
  endfunction

  logic signed [KW-1:0] k [4];
  logic signed [PW-1:0] prod_lo_nxt [3];
  logic signed [PW-1:0] prod_hi_nxt [3];
  logic signed [PW-1:0] prod_lo_r   [3];
  logic signed [PW-1:0] prod_hi_r   [3];
  logic signed [KW-1:0] d_r;
  logic [6*CW-1:0]      box1_r;
  logic [6*CW-1:0]      box2_r;
  fbc_pkg::fbc_ctl_t    ctl1_r;
  fbc_pkg::fbc_ctl_t    ctl2_r;
  fbc_pkg::fbc_ctl_t    ctl2_nxt;
  logic signed [PW-1:0] mx [3];
  logic signed [SW-1:0] plane_dist;

  // coefficients for this plane
  always_comb begin
    for (int j = 0; j < fbc_pkg::NUM_COLS; j++) begin
      k[j] = coef(cols[j*fbc_pkg::CFG_W +: fbc_pkg::CFG_W]);
    end
  end

  // stage 1: products of each axis coefficient with min and max
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_lo_nxt[i] = PW'(k[i]) * PW'($signed(box_in[i*CW +: CW]));
      prod_hi_nxt[i] = PW'(k[i]) * PW'($signed(box_in[(i+3)*CW +: CW]));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_lo_r[i] <= prod_lo_nxt[i];
      prod_hi_r[i] <= prod_hi_nxt[i];
    end
    d_r    <= k[3];
    box1_r <= box_in;
    box2_r <= box1_r;
  end

  // stage 2: best corner per axis, sum with scaled offset, sign test
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mx[i] = (prod_hi_r[i] > prod_lo_r[i]) ? prod_hi_r[i] : prod_lo_r[i];
    end
    plane_dist = SW'(mx[0]) + SW'(mx[1]) + SW'(mx[2]) + (SW'(d_r) <<< CF);
    ctl2_nxt.valid = ctl1_r.valid;
    ctl2_nxt.vis   = ctl1_r.vis & ~plane_dist[SW-1];
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl2_nxt;
    end
  end

  assign box_out = box2_r;
  assign ctl_out = ctl2_r;

endmodule

### hdl/fbc_fifo.sv
// Result queue, written by the end of the chain, read by the output channel.
module fbc_fifo #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic din,
  input  logic pop,
  output logic dout,
  output logic empty
);

  localparam int AW = $clog2(DEPTH);

  logic          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);

endmodule
